@@ src/ffba_pkg.sv @@
// Shared constants and result codes for the first-fit bitmap allocator.
// No dependencies.
package ffba_pkg;

	localparam int POOL_BYTES_DEF = 1024;
	localparam int WORD_BITS_DEF  = 16;

	localparam int LEN_W = 11;
	localparam int OFF_W = 10;
	localparam int ST_W  = 2;

	localparam logic MODE_ALLOC = 1'b0;
	localparam logic MODE_FREE  = 1'b1;

	localparam logic [ST_W-1:0] ST_OK      = 2'd0;
	localparam logic [ST_W-1:0] ST_NOSPACE = 2'd1;
	localparam logic [ST_W-1:0] ST_RANGE   = 2'd2;

endpackage

@@ src/ffba_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module ffba_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ src/first_fit_bitmap_allocator.sv @@
// First-fit bitmap allocator top level: used map in one RAM, scan and mark sequencer.
// Depends on ffba_pkg and ffba_ram.
//
// The used map holds one bit per pool byte in RAM words of WORD_BITS bits. After reset the
// block clears the map word by word and holds in_stall high meanwhile. An allocate scans
// the map one word per cycle from word 0 until the first fitting run ends or the map runs
// out, then does a read-modify-write on each word that the run touches. A free does a
// read-modify-write on each word it touches. Zero-length requests, too-long allocates and
// out-of-range frees answer without touching the map. One item is worked on at a time.
module first_fit_bitmap_allocator
	#(
	parameter int POOL_BYTES = ffba_pkg::POOL_BYTES_DEF,
	parameter int WORD_BITS  = ffba_pkg::WORD_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        mode,
	input  logic [ffba_pkg::LEN_W-1:0] length,
	input  logic [ffba_pkg::OFF_W-1:0] offset,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [ffba_pkg::ST_W-1:0]  status,
	output logic [ffba_pkg::OFF_W-1:0] start_offset
);
	import ffba_pkg::*;

	localparam int DEPTH = (POOL_BYTES + WORD_BITS - 1) / WORD_BITS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = $clog2(DEPTH + 1);
	localparam int LW    = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
	localparam int XW    = AW + LW;
	localparam int WW    = XW + 1;
	localparam int AB    = $clog2(POOL_BYTES + 1);
	localparam int SW    = (AB > LEN_W + 1) ? AB : LEN_W + 1;
	localparam int RW    = ((LEN_W > LW) ? LEN_W : LW) + 2;

	typedef enum logic [5:0] {
		S_CLEAR = 6'b000001,
		S_IDLE  = 6'b000010,
		S_SCAN  = 6'b000100,
		S_MRD   = 6'b001000,
		S_MWR   = 6'b010000,
		S_DONE  = 6'b100000
	} state_t;

	state_t              state_q;
	logic [AW-1:0]       clr_q;
	logic [CW-1:0]       iss_q;
	logic [AW-1:0]       ev_s1;
	logic                rv_s1;
	logic [LEN_W-1:0]    len_q;
	logic [RW-1:0]       run_q;
	logic [XW-1:0]       lo_q;
	logic [XW-1:0]       hi_q;
	logic [AW-1:0]       widx_q;
	logic                mark_q;
	logic [ST_W-1:0]     res_st_q;
	logic [OFF_W-1:0]    res_off_q;
	logic                out_valid_q;
	logic [ST_W-1:0]     status_q;
	logic [OFF_W-1:0]    start_q;

	logic                  we;
	logic [AW-1:0]         waddr;
	logic [WORD_BITS-1:0]  wdata;
	logic [AW-1:0]         raddr;
	logic [WORD_BITS-1:0]  rd_data;
	logic [WORD_BITS-1:0]  mask;
	logic [WORD_BITS-1:0]  clr_data;
	logic                  hit;
	logic [LW-1:0]         hit_bit;
	logic [RW-1:0]         run_last;
	logic [XW-1:0]         end_abs;
	logic [SW-1:0]         free_end;
	logic                  in_fire;
	logic                  out_fire;

	ffba_ram #(
		.WIDTH(WORD_BITS),
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_map (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rd_data)
	);

	assign in_fire   = in_valid && !in_stall;
	assign out_fire  = out_valid_q && !out_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign start_offset = start_q;
	assign free_end  = SW'(offset) + SW'(length);

	always_comb begin
		logic          found;
		logic [LW-1:0] last_used;
		logic [RW-1:0] run_i;
		hit      = 1'b0;
		hit_bit  = '0;
		run_last = '0;
		for (int i = 0; i < WORD_BITS; i++) begin
			found     = 1'b0;
			last_used = '0;
			for (int j = 0; j <= i; j++) begin
				if (rd_data[j]) begin
					found     = 1'b1;
					last_used = LW'(j);
				end
			end
			if (found) begin
				run_i = RW'(i) - RW'(last_used);
			end else begin
				run_i = run_q + RW'(i + 1);
			end
			if (!rd_data[i] && (run_i >= RW'(len_q)) && !hit) begin
				hit     = 1'b1;
				hit_bit = LW'(i);
			end
			if (i == WORD_BITS - 1) begin
				run_last = rd_data[i] ? '0 : run_i;
			end
		end
		end_abs = (XW'(ev_s1) << LW) | XW'(hit_bit);
	end

	always_comb begin
		logic [XW-1:0] a;
		logic [WW-1:0] b;
		for (int i = 0; i < WORD_BITS; i++) begin
			a           = (XW'(widx_q) << LW) | XW'(i);
			mask[i]     = (a >= lo_q) && (a <= hi_q);
			b           = (WW'(clr_q) << LW) | WW'(i);
			clr_data[i] = (b >= WW'(POOL_BYTES));
		end
	end

	always_comb begin
		we    = 1'b0;
		waddr = widx_q;
		wdata = mark_q ? (rd_data | mask) : (rd_data & ~mask);
		raddr = widx_q;
		unique case (state_q)
			S_CLEAR: begin
				we    = 1'b1;
				waddr = clr_q;
				wdata = clr_data;
			end
			S_SCAN: begin
				raddr = iss_q[AW-1:0];
			end
			S_MWR: begin
				we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			rv_s1       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_DONE && (!out_valid_q || !out_stall)) begin
				out_valid_q <= 1'b1;
			end else if (out_fire) begin
				out_valid_q <= 1'b0;
			end
			rv_s1 <= (state_q == S_SCAN) && (iss_q < CW'(DEPTH))
				&& !(rv_s1 && (hit || (ev_s1 == AW'(DEPTH - 1))));
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_fire) begin
						res_off_q <= '0;
						len_q     <= length;
						if (mode == MODE_ALLOC) begin
							mark_q <= 1'b1;
							if (length == '0) begin
								res_st_q <= ST_OK;
								state_q  <= S_DONE;
							end else if (SW'(length) > SW'(POOL_BYTES)) begin
								res_st_q <= ST_NOSPACE;
								state_q  <= S_DONE;
							end else begin
								res_st_q <= ST_OK;
								iss_q    <= '0;
								run_q    <= '0;
								state_q  <= S_SCAN;
							end
						end else begin
							mark_q <= 1'b0;
							if (free_end > SW'(POOL_BYTES)) begin
								res_st_q <= ST_RANGE;
								state_q  <= S_DONE;
							end else if (length == '0) begin
								res_st_q <= ST_OK;
								state_q  <= S_DONE;
							end else begin
								res_st_q <= ST_OK;
								lo_q     <= XW'(offset);
								hi_q     <= XW'(free_end - SW'(1));
								widx_q   <= AW'(XW'(offset) >> LW);
								state_q  <= S_MRD;
							end
						end
					end
				end
				S_SCAN: begin
					if (iss_q < CW'(DEPTH)) begin
						iss_q <= iss_q + CW'(1);
						ev_s1 <= iss_q[AW-1:0];
					end
					if (rv_s1) begin
						if (hit) begin
							lo_q      <= end_abs + XW'(1) - XW'(len_q);
							hi_q      <= end_abs;
							widx_q    <= AW'((end_abs + XW'(1) - XW'(len_q)) >> LW);
							res_off_q <= OFF_W'(end_abs + XW'(1) - XW'(len_q));
							state_q   <= S_MRD;
						end else if (ev_s1 == AW'(DEPTH - 1)) begin
							res_st_q <= ST_NOSPACE;
							state_q  <= S_DONE;
						end else begin
							run_q <= run_last;
						end
					end
				end
				S_MRD: begin
					state_q <= S_MWR;
				end
				S_MWR: begin
					if (widx_q == AW'(hi_q >> LW)) begin
						state_q <= S_DONE;
					end else begin
						widx_q  <= widx_q + AW'(1);
						state_q <= S_MRD;
					end
				end
				S_DONE: begin
					if (!out_valid_q || !out_stall) begin
						status_q    <= res_st_q;
						start_q     <= res_off_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_CLEAR;
				end
			endcase
		end
	end

`ifndef SYNTH
	a_write_state: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> (state_q == S_CLEAR || state_q == S_MWR))
		else $error("map written outside clear or mark");
	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_DONE))
		else $error("result raised without completion");
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (status_q == ST_OK || status_q == ST_NOSPACE || status_q == ST_RANGE))
		else $error("bad status code");
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q != ST_OK) |-> (start_q == '0))
		else $error("failed item carries nonzero offset");
	a_mark_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MWR) |-> (widx_q <= AW'(hi_q >> LW)))
		else $error("mark word beyond run end");
`endif

endmodule

@@ sim/tb.sv @@
// Self-checking testbench for first_fit_bitmap_allocator: directed and random allocate/free items.
// Depends on ffba_pkg and the allocator RTL; expected results come from a bitmap predictor here.
`timescale 1ns / 1ps

class alloc_scoreboard;
	bit               pool_used[1024];
	logic [1:0]       exp_status[$];
	logic [9:0]       exp_start[$];
	int               errors;

	function void note_request(logic m, logic [10:0] len, logic [9:0] off);
		int run;
		int j;
		int s;
		logic [1:0] st;
		logic [9:0] so;
		st = ffba_pkg::ST_OK;
		so = '0;
		if (m == ffba_pkg::MODE_ALLOC) begin
			if (len == 0) begin
				st = ffba_pkg::ST_OK;
			end else if (len > 1024) begin
				st = ffba_pkg::ST_NOSPACE;
			end else begin
				st = ffba_pkg::ST_NOSPACE;
				run = 0;
				for (j = 0; j < 1024; j++) begin
					if (pool_used[j]) begin
						run = 0;
					end else begin
						run++;
						if (run == len) begin
							s = j + 1 - len;
							for (int k = s; k <= j; k++) pool_used[k] = 1'b1;
							st = ffba_pkg::ST_OK;
							so = s[9:0];
							break;
						end
					end
				end
			end
		end else begin
			if (int'(off) + int'(len) > 1024) begin
				st = ffba_pkg::ST_RANGE;
			end else begin
				for (int k = 0; k < len; k++) pool_used[off + k] = 1'b0;
			end
		end
		exp_status.push_back(st);
		exp_start.push_back(so);
	endfunction

	function void check_result(logic [1:0] st, logic [9:0] so);
		logic [1:0] es;
		logic [9:0] eo;
		if (exp_status.size() == 0) begin
			$display("%0t: unexpected result status %0d start %0d", $time, st, so);
			errors++;
			return;
		end
		es = exp_status.pop_front();
		eo = exp_start.pop_front();
		if (st !== es) begin
			$display("%0t: status expected %0d actual %0d", $time, es, st);
			errors++;
		end
		if (so !== eo) begin
			$display("%0t: start_offset expected %0d actual %0d", $time, eo, so);
			errors++;
		end
	endfunction
endclass

module tb;
	import ffba_pkg::*;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic              mode;
	logic [LEN_W-1:0]  length;
	logic [OFF_W-1:0]  offset;
	logic              out_valid;
	logic              out_stall;
	logic [ST_W-1:0]   status;
	logic [OFF_W-1:0]  start_offset;

	alloc_scoreboard sb;
	int              cycle_count;
	bit              hold_off;
	bit              stim_done;
	logic [9:0]      live_off[$];
	logic [10:0]     live_len[$];

	first_fit_bitmap_allocator dut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.mode(mode), .length(length), .offset(offset), .out_valid(out_valid),
		.out_stall(out_stall), .status(status), .start_offset(start_offset)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	task automatic send_request(logic m, logic [10:0] len, logic [9:0] off, bit gaps);
		int gap;
		gap = gaps ? $urandom_range(0, 13) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		length <= len;
		offset <= off;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_request(m, len, off);
	endtask

	task automatic send_random(bit gaps);
		int r;
		int idx;
		logic [10:0] len;
		r = $urandom_range(0, 99);
		if (r < 45) begin
			len = ($urandom_range(0, 9) == 0) ? 11'($urandom_range(0, 2047))
				: 11'($urandom_range(0, 64));
			send_request(MODE_ALLOC, len, 10'($urandom), gaps);
			if (sb.exp_status[$] == ST_OK && len != 0) begin
				live_off.push_back(sb.exp_start[$]);
				live_len.push_back(len);
			end
		end else if (r < 85 && live_off.size() > 0) begin
			idx = $urandom_range(0, live_off.size() - 1);
			send_request(MODE_FREE, live_len[idx], live_off[idx], gaps);
			live_off.delete(idx);
			live_len.delete(idx);
		end else begin
			send_request(MODE_FREE, 11'($urandom_range(0, 2047)), 10'($urandom), gaps);
		end
	endtask

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 2000000) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) sb.check_result(status, start_offset);
	end

	initial begin
		int gap;
		out_stall = 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_off) begin
				out_stall <= 1'b1;
				repeat (300) @(posedge clk);
				out_stall <= 1'b0;
				hold_off = 1'b0;
			end else if (!stim_done && $urandom_range(0, 3) == 0) begin
				gap = $urandom_range(0, 13);
				if (gap > 0) begin
					out_stall <= 1'b1;
					repeat (gap) @(posedge clk);
					out_stall <= 1'b0;
				end
			end
		end
	end

	initial begin
		int waited;
		sb = new();
		cycle_count = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		mode = MODE_ALLOC;
		length = '0;
		offset = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_request(MODE_ALLOC, 11'd0, 10'h3ff, 0);
		send_request(MODE_ALLOC, 11'd1025, 10'd0, 0);
		send_request(MODE_ALLOC, 11'd2047, 10'd0, 0);
		send_request(MODE_ALLOC, 11'd1024, 10'd0, 0);
		send_request(MODE_ALLOC, 11'd1, 10'd0, 0);
		send_request(MODE_FREE, 11'd1024, 10'd0, 0);
		send_request(MODE_ALLOC, 11'd1023, 10'd0, 0);
		send_request(MODE_ALLOC, 11'd1, 10'd0, 0);
		send_request(MODE_ALLOC, 11'd1, 10'd0, 0);
		send_request(MODE_FREE, 11'd1, 10'h3ff, 0);
		send_request(MODE_FREE, 11'd2, 10'h3ff, 0);
		send_request(MODE_FREE, 11'd0, 10'h3ff, 0);
		send_request(MODE_FREE, 11'd2047, 10'h3ff, 0);
		send_request(MODE_ALLOC, 11'd1, 10'd0, 0);
		send_request(MODE_FREE, 11'd10, 10'd100, 0);
		send_request(MODE_FREE, 11'd10, 10'd100, 0);
		send_request(MODE_ALLOC, 11'd11, 10'd0, 0);
		send_request(MODE_ALLOC, 11'd10, 10'd0, 0);
		send_request(MODE_FREE, 11'd1024, 10'd0, 0);
		send_request(MODE_ALLOC, 11'd1024, 10'd0, 0);
		send_request(MODE_FREE, 11'd1024, 10'd0, 0);

		for (int i = 0; i < 800; i++) send_random(($urandom_range(0, 4) != 0) && (i < 400 || i > 600));
		hold_off = 1'b1;
		for (int i = 0; i < 30; i++) send_random(0);
		for (int i = 0; i < 800; i++) send_random(i % 200 >= 40);
		in_valid <= 1'b0;
		stim_done = 1'b1;

		waited = 0;
		while (sb.exp_status.size() != 0 && waited < 100000) begin
			@(posedge clk);
			waited++;
		end
		repeat (200) @(posedge clk);
		if (sb.errors == 0 && sb.exp_status.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end
endmodule

@@ files.f @@
src/ffba_pkg.sv
src/ffba_ram.sv
src/first_fit_bitmap_allocator.sv
sim/tb.sv
